FILE: design/dcd_pkg.sv
// Shared types and constants for the daylight clock dimmer.
package dcd_pkg;

  localparam int TOD_W = 17;
  localparam int NUM_W = 25;
  localparam int Q_W   = 8;
  localparam int CNT_W = $clog2(Q_W);

  localparam logic [TOD_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [NUM_W-1:0] DUTY_SLOPE   = 25'd253;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  localparam logic [4:0] HOUR_RESET   = 5'd16;
  localparam logic [5:0] MINUTE_RESET = 6'd30;
  localparam logic [5:0] SECOND_RESET = 6'd0;

  localparam logic [TOD_W-1:0] SUNRISE_RESET = 17'd21600;
  localparam logic [TOD_W-1:0] DAY_RESET     = 17'd28800;
  localparam logic [TOD_W-1:0] SUNSET_RESET  = 17'd64800;
  localparam logic [TOD_W-1:0] NIGHT_RESET   = 17'd72000;

  localparam logic [1:0] REG_SUNRISE = 2'd0;
  localparam logic [1:0] REG_DAY     = 2'd1;
  localparam logic [1:0] REG_SUNSET  = 2'd2;
  localparam logic [1:0] REG_NIGHT   = 2'd3;

  localparam logic [1:0] PHASE_SUNRISE = 2'd0;
  localparam logic [1:0] PHASE_DAY     = 2'd1;
  localparam logic [1:0] PHASE_SUNSET  = 2'd2;
  localparam logic [1:0] PHASE_NIGHT   = 2'd3;

  localparam logic [Q_W-1:0] DUTY_MIN = 8'd1;
  localparam logic [Q_W-1:0] DUTY_MAX = 8'd254;
  localparam logic [Q_W-1:0] QUOT_MAX = 8'd253;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dcd_time_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [TOD_W-1:0] den;
  } dcd_div_req_t;

endpackage

FILE: design/dcd_clock.sv
// Hour:minute:second counter with midnight rollover.
module dcd_clock
  import dcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      tick,
  output dcd_time_t now
);

  dcd_time_t now_next;

  always_comb begin
    now_next = now;
    if (now.second == SEC_LAST) begin
      now_next.second = '0;
      if (now.minute == MIN_LAST) begin
        now_next.minute = '0;
        if (now.hour == HOUR_LAST) begin
          now_next.hour = '0;
        end else begin
          now_next.hour = now.hour + 5'd1;
        end
      end else begin
        now_next.minute = now.minute + 6'd1;
      end
    end else begin
      now_next.second = now.second + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now.hour   <= HOUR_RESET;
      now.minute <= MINUTE_RESET;
      now.second <= SECOND_RESET;
    end else if (tick) begin
      now <= now_next;
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    now.second <= SEC_LAST && now.minute <= MIN_LAST && now.hour <= HOUR_LAST)
    else $error("clock left its valid range");

endmodule

FILE: design/dcd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module dcd_divider
  import dcd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  dcd_div_req_t   req,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= NUM_W'({req.den, {(Q_W-1){1'b0}}});
      cnt  <= CNT_W'(Q_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      cnt  <= cnt - CNT_W'(1);
      quot <= {quot[Q_W-2:0], ge};
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

FILE: design/daylight_clock_dimmer.sv
// Top level: day clock, phase compare and lamp duty sequencer.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   tick     | tick_valid / tick_stall  | advance
//   result   | result_valid / result_stall | hour, minute, second, phase, duty
//   config   | cfg_we                   | cfg_index, cfg_data
//
// A transaction outside the ramps passes S_TOD, S_EVAL and S_DONE from accept
// to accept; on a ramp S_WAIT lies before S_DONE, held for the 8 steps of the shared divider.
// Reset clears the clock to 16:30:00 and loads the default boundaries.
// tick_stall is high while a transaction is in work or its result cannot
// be placed; result_stall holds the result register.
module daylight_clock_dimmer
  import dcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  output logic             tick_stall,
  input  logic             advance,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [1:0]       phase,
  output logic [7:0]       duty,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [TOD_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOD,
    S_EVAL,
    S_WAIT,
    S_DONE
  } state_t;

  state_t           state;
  dcd_time_t        now;
  logic             accept;
  logic [TOD_W-1:0] tod;
  logic [TOD_W-1:0] sunrise_start;
  logic [TOD_W-1:0] day_start;
  logic [TOD_W-1:0] sunset_start;
  logic [TOD_W-1:0] night_start;
  logic [1:0]       phase_sel;
  logic             ramp;
  logic [TOD_W-1:0] diff;
  logic [TOD_W-1:0] span;
  logic [1:0]       phase_hold;
  logic [Q_W-1:0]   duty_hold;
  dcd_div_req_t     div_req;
  logic             div_done;
  logic [Q_W-1:0]   div_quot;
  logic             out_free;

  assign tick_stall = (state != S_IDLE);
  assign accept     = tick_valid && !tick_stall;
  assign out_free   = !result_valid || !result_stall;

  dcd_clock u_clock (
    .clk  (clk),
    .rst  (rst),
    .tick (accept && advance),
    .now  (now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sunrise_start <= SUNRISE_RESET;
      day_start     <= DAY_RESET;
      sunset_start  <= SUNSET_RESET;
      night_start   <= NIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUNRISE: sunrise_start <= cfg_data;
        REG_DAY:     day_start     <= cfg_data;
        REG_SUNSET:  sunset_start  <= cfg_data;
        REG_NIGHT:   night_start   <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_comb begin
    phase_sel = PHASE_NIGHT;
    ramp      = 1'b0;
    diff      = '0;
    span      = '0;
    if (tod < sunrise_start) begin
      phase_sel = PHASE_NIGHT;
    end else if (tod < day_start) begin
      phase_sel = PHASE_SUNRISE;
      ramp      = 1'b1;
      diff      = tod - sunrise_start;
      span      = day_start - sunrise_start;
    end else if (tod < sunset_start) begin
      phase_sel = PHASE_DAY;
    end else if (tod < night_start) begin
      phase_sel = PHASE_SUNSET;
      ramp      = 1'b1;
      diff      = night_start - tod;
      span      = night_start - sunset_start;
    end
  end

  assign div_req.start = (state == S_EVAL) && ramp;
  assign div_req.num   = NUM_W'(diff) * DUTY_SLOPE;
  assign div_req.den   = span;

  dcd_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_TOD;
          end
        end
        S_TOD: begin
          tod   <= TOD_W'(now.hour) * SEC_PER_HOUR + TOD_W'(now.minute) * SEC_PER_MIN
                   + TOD_W'(now.second);
          state <= S_EVAL;
        end
        S_EVAL: begin
          phase_hold <= phase_sel;
          if (ramp) begin
            state <= S_WAIT;
          end else begin
            duty_hold <= (phase_sel == PHASE_DAY) ? DUTY_MAX : DUTY_MIN;
            state     <= S_DONE;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            duty_hold <= div_quot + DUTY_MIN;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            hour   <= now.hour;
            minute <= now.minute;
            second <= now.second;
            phase  <= phase_hold;
            duty   <= duty_hold;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_quot <= QUOT_MAX)
    else $error("ramp quotient out of range");

  a_day_duty: assert property (@(posedge clk) disable iff (rst)
    result_valid && phase == PHASE_DAY |-> duty == DUTY_MAX)
    else $error("day phase without full duty");

  a_night_duty: assert property (@(posedge clk) disable iff (rst)
    result_valid && phase == PHASE_NIGHT |-> duty == DUTY_MIN)
    else $error("night phase without minimum duty");

endmodule

FILE: test/daylight_clock_dimmer_tb.sv
// Testbench for daylight_clock_dimmer: random tick traffic checked against a day clock predictor.
module daylight_clock_dimmer_tb;
  import dcd_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int REPORT_CAP  = 100;
  localparam int BATCHES     = 9;
  localparam int BATCH_ITEMS = 200;
  localparam int SETTLE      = 16;
  localparam logic [TOD_W-1:0] TOD_ALL_ONES = '1;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [1:0] phase;
    logic [7:0] duty;
  } lamp_reading_t;

  typedef enum {WINDOW, SCATTER, TANGLED, EXTREME} bound_style_e;

  logic             clk;
  logic             rst = 1'b1;
  logic             tick_valid = 1'b0;
  logic             tick_stall;
  logic             advance = 1'b0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [5:0]       second;
  logic [1:0]       phase;
  logic [7:0]       duty;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_SUNRISE;
  logic [TOD_W-1:0] cfg_data = '0;

  // predictor state
  int unsigned      clk_h = HOUR_RESET;
  int unsigned      clk_m = MINUTE_RESET;
  int unsigned      clk_s = SECOND_RESET;
  logic [TOD_W-1:0] bound [4] = '{SUNRISE_RESET, DAY_RESET, SUNSET_RESET, NIGHT_RESET};

  logic          pending_advance [$];
  lamp_reading_t expected_readings [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int reports = 0;
  int ticks_taken = 0;
  int readings_checked = 0;
  int reg_writes = 0;
  int quiet = 0;

  daylight_clock_dimmer u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .phase        (phase),
    .duty         (duty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned tod_now();
    return clk_h * 3600 + clk_m * 60 + clk_s;
  endfunction

  function automatic lamp_reading_t step_clock(input logic adv);
    int unsigned tod;
    int unsigned sr;
    int unsigned dy;
    int unsigned ss;
    int unsigned ns;
    lamp_reading_t r;
    if (adv) begin
      clk_s++;
      if (clk_s >= 60) begin
        clk_s = 0;
        clk_m++;
      end
      if (clk_m >= 60) begin
        clk_m = 0;
        clk_h++;
      end
      if (clk_h >= 24) begin
        clk_h = 0;
        clk_m = 0;
        clk_s = 0;
      end
    end
    tod = tod_now();
    sr = bound[REG_SUNRISE];
    dy = bound[REG_DAY];
    ss = bound[REG_SUNSET];
    ns = bound[REG_NIGHT];
    r.hour   = 5'(clk_h);
    r.minute = 6'(clk_m);
    r.second = 6'(clk_s);
    if (tod < sr) begin
      r.phase = PHASE_NIGHT;
      r.duty  = DUTY_MIN;
    end else if (tod < dy) begin
      r.phase = PHASE_SUNRISE;
      r.duty  = 8'(QUOT_MAX * (tod - sr) / (dy - sr) + DUTY_MIN);
    end else if (tod < ss) begin
      r.phase = PHASE_DAY;
      r.duty  = DUTY_MAX;
    end else if (tod < ns) begin
      r.phase = PHASE_SUNSET;
      r.duty  = 8'(QUOT_MAX * (ns - tod) / (ns - ss) + DUTY_MIN);
    end else begin
      r.phase = PHASE_NIGHT;
      r.duty  = DUTY_MIN;
    end
    return r;
  endfunction

  function automatic string reading_str(input lamp_reading_t r);
    return $sformatf("%0d:%0d:%0d phase %0d duty %0d",
                     r.hour, r.minute, r.second, r.phase, r.duty);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall) begin
        expected_readings.push_back(step_clock(advance));
        ticks_taken++;
      end
      if (!tick_valid || !tick_stall) begin
        if (pending_advance.size() > 0 && $urandom_range(99) >= send_idle) begin
          tick_valid <= 1'b1;
          advance    <= pending_advance.pop_front();
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lamp_reading_t got;
    lamp_reading_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = '{hour, minute, second, phase, duty};
        if (expected_readings.size() == 0) begin
          errors++;
          if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: result with no transaction pending: %s", $time, reading_str(got));
          end
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (got.hour !== want.hour || got.minute !== want.minute ||
              got.second !== want.second || got.phase !== want.phase ||
              got.duty !== want.duty) begin
            errors++;
            if (reports < REPORT_CAP) begin
              reports++;
              $display("%0t: mismatch expected %s actual %s", $time,
                       reading_str(want), reading_str(got));
            end
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("daylight_clock_dimmer_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [TOD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    bound[idx] = val;
    reg_writes++;
  endtask

  task automatic set_bounds(input int unsigned sr, input int unsigned dy,
                            input int unsigned ss, input int unsigned ns);
    write_reg(REG_SUNRISE, TOD_W'(sr));
    write_reg(REG_DAY, TOD_W'(dy));
    write_reg(REG_SUNSET, TOD_W'(ss));
    write_reg(REG_NIGHT, TOD_W'(ns));
  endtask

  // wait until every transaction has come back, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (pending_advance.size() != 0 || tick_valid || expected_readings.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned t;
    int unsigned sr;
    int unsigned dy;
    int unsigned ss;
    int unsigned ns;
    bound_style_e style;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle = 31;
    recv_idle = 81;

    // reset clock and boundaries, re-evaluate then advance
    pending_advance.push_back(1'b0);
    pending_advance.push_back(1'b1);
    drain();

    // walk across every phase edge with spans of two
    t = tod_now();
    set_bounds(t + 2, t + 4, t + 6, t + 8);
    repeat (9) pending_advance.push_back(1'b1);
    pending_advance.push_back(1'b0);
    drain();

    // span of one, sunset before day, night at the top of the range
    t = tod_now();
    set_bounds(t + 1, t + 2, t + 1, TOD_ALL_ONES);
    pending_advance.push_back(1'b1);
    pending_advance.push_back(1'b1);
    pending_advance.push_back(1'b0);
    drain();

    // all boundaries at zero
    set_bounds(0, 0, 0, 0);
    pending_advance.push_back(1'b0);
    pending_advance.push_back(1'b1);
    drain();

    for (int b = 0; b < BATCHES; b++) begin
      if (b < 3) begin
        send_idle = 31;
        recv_idle = 81;
      end else if (b < 6) begin
        send_idle = 81;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (b)
        2:       style = SCATTER;
        5:       style = TANGLED;
        8:       style = EXTREME;
        default: style = WINDOW;
      endcase
      t = tod_now();
      case (style)
        WINDOW: begin
          sr = t + $urandom_range(0, 15);
          dy = sr + $urandom_range(1, 50);
          ss = dy + $urandom_range(0, 25);
          ns = ss + $urandom_range(1, 50);
        end
        SCATTER: begin
          sr = $urandom_range(0, 131071);
          dy = $urandom_range(0, 131071);
          ss = $urandom_range(0, 131071);
          ns = $urandom_range(0, 131071);
        end
        TANGLED: begin
          sr = t + $urandom_range(20, 60);
          dy = t + $urandom_range(0, 40);
          ss = t + $urandom_range(0, 80);
          ns = t + $urandom_range(0, 120);
        end
        default: begin
          sr = 0;
          dy = TOD_ALL_ONES;
          ss = 0;
          ns = TOD_ALL_ONES;
        end
      endcase
      set_bounds(sr, dy, ss, ns);
      repeat (BATCH_ITEMS) pending_advance.push_back($urandom_range(9) < 7);
      drain();
    end

    // default boundaries again, mixed advance and re-evaluate
    set_bounds(SUNRISE_RESET, DAY_RESET, SUNSET_RESET, NIGHT_RESET);
    repeat (20) pending_advance.push_back($urandom_range(1));
    drain();

    $display("Run covered %0d tick transactions and %0d checked readings, %0d register writes,",
             ticks_taken, readings_checked, reg_writes);
    $display("all four phases under ordered, tangled and extreme boundaries with stalls.");
    if (errors == 0) begin
      $display("daylight_clock_dimmer_tb passed");
    end else begin
      $display("daylight_clock_dimmer_tb failed");
    end
    $finish;
  end

endmodule
